>>> rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Types, operation codes and constants shared by the checked int64 ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned HalfWidth = DataWidth / 2;
   localparam int unsigned DivSteps  = DataWidth;

   localparam logic [DataWidth-1:0] Int64Min = {1'b1, {(DataWidth-1){1'b0}}};
   localparam logic [DataWidth-1:0] Int64Max = {1'b0, {(DataWidth-1){1'b1}}};

   typedef enum logic [4:0] {
      OP_COPY = 5'd0,
      OP_ADD  = 5'd1,
      OP_SUB  = 5'd2,
      OP_MUL  = 5'd3,
      OP_DIV  = 5'd4,
      OP_REM  = 5'd5,
      OP_AND  = 5'd6,
      OP_OR   = 5'd7,
      OP_XOR  = 5'd8,
      OP_NEG  = 5'd9,
      OP_NOT  = 5'd10,
      OP_ABS  = 5'd11,
      OP_EVEN = 5'd12,
      OP_ODD  = 5'd13,
      OP_EQ   = 5'd14,
      OP_GE   = 5'd15,
      OP_GT   = 5'd16
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_INEXACT  = 2'd3
   } status_type;

   typedef struct packed {
      logic [4:0]                  action;
      logic signed [DataWidth-1:0] operand_a;
      logic signed [DataWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] result;
      logic                        truth;
      logic [1:0]                  status;
   } rsp_type;

   // decoded request and the outcome of the simple operations
   typedef struct packed {
      logic [4:0]           action;
      logic                 na;
      logic                 nb;
      logic                 b_zero;
      logic                 b_minus_one;
      logic                 a_min;
      logic [DataWidth-1:0] simple_res;
      logic                 simple_truth;
      logic [1:0]           simple_status;
   } ctl_type;

   typedef struct packed {
      ctl_type              ctl;
      logic [DataWidth-1:0] ma;
      logic [DataWidth-1:0] mb;
      logic                 mul_ovf;
      logic [DataWidth-1:0] mul_mag;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] dq;
   } pipe_type;

endpackage

>>> rtl/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front
// Decode stage: operand magnitudes, flags and all operations but MUL, DIV, REM.
// ----------------------------------------------------------------------------
module cia_front import cia_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  req_type  in_req,
   output logic     out_valid,
   output pipe_type out_pipe
);

   logic                 valid_ff, valid_in;
   pipe_type             pipe_ff, pipe_in;
   logic [DataWidth-1:0] a, b, sum, dif, ma, mb, res;
   logic                 na, nb, truth;
   logic [1:0]           st;

   always_comb begin
      a   = in_req.operand_a;
      b   = in_req.operand_b;
      na  = a[DataWidth-1];
      nb  = b[DataWidth-1];
      sum = a + b;
      dif = a - b;
      ma  = na ? (~a + 1'b1) : a;
      mb  = nb ? (~b + 1'b1) : b;
      res   = '0;
      truth = 1'b0;
      st    = ST_OK;
      case (in_req.action)
         OP_COPY: res = a;
         OP_ADD: begin
            res = sum;
            if (na == nb && sum[DataWidth-1] != na) st = ST_OVERFLOW;
         end
         OP_SUB: begin
            res = dif;
            if (na != nb && dif[DataWidth-1] != na) st = ST_OVERFLOW;
         end
         OP_AND: res = a & b;
         OP_OR:  res = a | b;
         OP_XOR: res = a ^ b;
         OP_NEG: begin
            if (a == Int64Min) st = ST_OVERFLOW;
            else res = ~a + 1'b1;
         end
         OP_NOT: res = ~a;
         OP_ABS: begin
            if (a == Int64Min) st = ST_OVERFLOW;
            else res = ma;
         end
         OP_EVEN: truth = ~a[0];
         OP_ODD:  truth = a[0];
         OP_EQ:   truth = (a == b);
         OP_GE:   truth = ($signed(a) >= $signed(b));
         OP_GT:   truth = ($signed(a) > $signed(b));
         default: res = '0;
      endcase
      if (st != ST_OK) res = '0;

      pipe_in                   = pipe_ff;
      pipe_in.ctl.action        = in_req.action;
      pipe_in.ctl.na            = na;
      pipe_in.ctl.nb            = nb;
      pipe_in.ctl.b_zero        = (b == '0);
      pipe_in.ctl.b_minus_one   = (b == '1);
      pipe_in.ctl.a_min         = (a == Int64Min);
      pipe_in.ctl.simple_res    = res;
      pipe_in.ctl.simple_truth  = truth;
      pipe_in.ctl.simple_status = st;
      pipe_in.ma                = ma;
      pipe_in.mb                = mb;
      pipe_in.mul_ovf           = 1'b0;
      pipe_in.mul_mag           = '0;
      pipe_in.rem               = '0;
      pipe_in.dq                = ma;
      valid_in                  = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

>>> rtl/cia_mul.sv
// ----------------------------------------------------------------------------
// cia_mul
// Four-stage unsigned 64x64 magnitude multiplier with signed range check.
// ----------------------------------------------------------------------------
module cia_mul import cia_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  pipe_type in_pipe,
   output logic     out_valid,
   output pipe_type out_pipe
);

   logic [3:0]             valid_ff, valid_in;
   pipe_type               p1_ff, p2_ff, p3_ff, p4_ff;
   pipe_type               p4_in;
   logic [DataWidth-1:0]   ll_ff, lh_ff, hl_ff, hh_ff;
   logic [DataWidth-1:0]   ll2_ff, hh2_ff;
   logic [DataWidth:0]     mid_ff, mid_in;
   logic [2*DataWidth-1:0] prod_ff, prod_in;
   logic [DataWidth-1:0]   limit;

   always_comb begin
      valid_in = {valid_ff[2:0], in_valid};
      mid_in   = {1'b0, lh_ff} + {1'b0, hl_ff};
      prod_in  = {hh2_ff, ll2_ff} + ({{(DataWidth-1){1'b0}}, mid_ff} << HalfWidth);
      limit    = (p3_ff.ctl.na ^ p3_ff.ctl.nb) ? Int64Min : Int64Max;
      p4_in         = p3_ff;
      p4_in.mul_ovf = (prod_ff[2*DataWidth-1:DataWidth] != '0) ||
                      (prod_ff[DataWidth-1:0] > limit);
      p4_in.mul_mag = prod_ff[DataWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= in_pipe;
         ll_ff   <= in_pipe.ma[HalfWidth-1:0] * in_pipe.mb[HalfWidth-1:0];
         lh_ff   <= in_pipe.ma[HalfWidth-1:0] * in_pipe.mb[DataWidth-1:HalfWidth];
         hl_ff   <= in_pipe.ma[DataWidth-1:HalfWidth] * in_pipe.mb[HalfWidth-1:0];
         hh_ff   <= in_pipe.ma[DataWidth-1:HalfWidth] * in_pipe.mb[DataWidth-1:HalfWidth];
         p2_ff   <= p1_ff;
         mid_ff  <= mid_in;
         ll2_ff  <= ll_ff;
         hh2_ff  <= hh_ff;
         p3_ff   <= p2_ff;
         prod_ff <= prod_in;
         p4_ff   <= p4_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_pipe  = p4_ff;

endmodule

>>> rtl/cia_div_step.sv
// ----------------------------------------------------------------------------
// cia_div_step
// One restoring-division step: develops one quotient bit per stage.
// ----------------------------------------------------------------------------
module cia_div_step import cia_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  pipe_type in_pipe,
   output logic     out_valid,
   output pipe_type out_pipe
);

   logic               valid_ff;
   pipe_type           pipe_ff, pipe_in;
   logic [DataWidth:0] trial, diff;

   always_comb begin
      trial   = {in_pipe.rem, in_pipe.dq[DataWidth-1]};
      diff    = trial - {1'b0, in_pipe.mb};
      pipe_in = in_pipe;
      if (!diff[DataWidth]) begin
         pipe_in.rem = diff[DataWidth-1:0];
         pipe_in.dq  = {in_pipe.dq[DataWidth-2:0], 1'b1};
      end else begin
         pipe_in.rem = trial[DataWidth-1:0];
         pipe_in.dq  = {in_pipe.dq[DataWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

>>> rtl/cia_final.sv
// ----------------------------------------------------------------------------
// cia_final
// Result stage: MUL, DIV, REM or simple result; applies sign and status.
// ----------------------------------------------------------------------------
module cia_final import cia_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  pipe_type in_pipe,
   output logic     out_valid,
   output rsp_type  out_rsp
);

   logic                 valid_ff;
   rsp_type              rsp_ff, rsp_in;
   logic [DataWidth-1:0] mag, val;
   logic                 neg;
   logic [1:0]           st;
   ctl_type              c;

   always_comb begin
      c   = in_pipe.ctl;
      mag = '0;
      neg = 1'b0;
      st  = c.simple_status;
      case (c.action)
         OP_MUL: begin
            mag = in_pipe.mul_mag;
            neg = c.na ^ c.nb;
            st  = in_pipe.mul_ovf ? ST_OVERFLOW : ST_OK;
         end
         OP_DIV: begin
            mag = in_pipe.dq;
            neg = c.na ^ c.nb;
            if (c.b_zero) st = ST_DIV_ZERO;
            else if (c.a_min && c.b_minus_one) st = ST_OVERFLOW;
            else if (in_pipe.rem != '0) st = ST_INEXACT;
            else st = ST_OK;
         end
         OP_REM: begin
            mag = in_pipe.rem;
            neg = c.na;
            st  = c.b_zero ? ST_DIV_ZERO : ST_OK;
         end
         default: mag = '0;
      endcase
      val = neg ? (~mag + 1'b1) : mag;
      rsp_in.status = st;
      rsp_in.truth  = c.simple_truth;
      if (st != ST_OK) begin
         rsp_in.result = '0;
      end else if (c.action == OP_MUL || c.action == OP_DIV || c.action == OP_REM) begin
         rsp_in.result = val;
      end else begin
         rsp_in.result = c.simple_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> rtl/checked_int64_alu_core.sv
// ----------------------------------------------------------------------------
// checked_int64_alu_core
// Overflow-checked signed 64-bit ALU, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one request per clock while not stalled and returns one response
// per request, in order, through 70 register stages: one decode stage, four
// multiplier stages, one stage per quotient bit of the 64-step restoring
// divider, and a result stage. The pipeline advances as a whole whenever the
// output register is empty or being taken, so rsp_ready low with a response
// held stalls every stage and req_ready follows it.
module checked_int64_alu_core import cia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     en;
   logic     front_valid, mul_valid;
   pipe_type front_pipe, mul_pipe;
   logic     div_valid [0:DivSteps];
   pipe_type div_pipe  [0:DivSteps];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   cia_front u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_req(req_data),
      .out_valid(front_valid), .out_pipe(front_pipe)
   );

   cia_mul u_mul (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(front_valid), .in_pipe(front_pipe),
      .out_valid(mul_valid), .out_pipe(mul_pipe)
   );

   assign div_valid[0] = mul_valid;
   assign div_pipe[0]  = mul_pipe;

   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      cia_div_step u_step (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(div_valid[i]), .in_pipe(div_pipe[i]),
         .out_valid(div_valid[i+1]), .out_pipe(div_pipe[i+1])
      );
   end

   cia_final u_final (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(div_valid[DivSteps]), .in_pipe(div_pipe[DivSteps]),
      .out_valid(rsp_valid), .out_rsp(rsp_data)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.result == '0)
      else $error("error status with nonzero result");

   a_truth_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.truth |-> rsp_data.result == '0 && rsp_data.status == ST_OK)
      else $error("test outcome mixed with arithmetic result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

>>> test/checked_int64_alu_core_tb.sv
// ----------------------------------------------------------------------------
// checked_int64_alu_core_tb
// Self-checking bench for the overflow-checked 64-bit ALU: directed corner
// requests for every operation but OR and ODD, then random requests under varied idling.
// ----------------------------------------------------------------------------
module checked_int64_alu_core_tb;
   import cia_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;
   localparam int Latency       = 70;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type expected_q[$];
   int      error_count;
   int      sent_count;
   int      checked_count;
   int      idle_cycles;
   int      send_idle_pct;
   int      stall_pct;

   checked_int64_alu_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] mag(logic [63:0] v);
      return v[63] ? 64'd0 - v : v;
   endfunction

   function automatic rsp_type alu_outcome(req_type r);
      rsp_type     o;
      logic [63:0] a, b, s, ma, mb, lim, q;
      logic        na, nb, neg;
      a = r.operand_a;
      b = r.operand_b;
      na = a[63];
      nb = b[63];
      o = '0;
      ma = mag(a);
      mb = mag(b);
      case (r.action)
         OP_COPY: o.result = a;
         OP_ADD: begin
            s = a + b;
            o.result = s;
            if (na == nb && s[63] != na) o.status = ST_OVERFLOW;
         end
         OP_SUB: begin
            s = a - b;
            o.result = s;
            if (na != nb && s[63] != na) o.status = ST_OVERFLOW;
         end
         OP_MUL: begin
            neg = na != nb;
            lim = neg ? Int64Min : Int64Max;
            if (ma != 0 && mb != 0 && ma > lim / mb) o.status = ST_OVERFLOW;
            else o.result = neg ? 64'd0 - ma * mb : ma * mb;
         end
         OP_DIV: begin
            if (b == 0) o.status = ST_DIV_ZERO;
            else if (a == Int64Min && b == '1) o.status = ST_OVERFLOW;
            else if (ma % mb != 0) o.status = ST_INEXACT;
            else begin
               q = ma / mb;
               o.result = (na != nb) ? 64'd0 - q : q;
            end
         end
         OP_REM: begin
            if (b == 0) o.status = ST_DIV_ZERO;
            else if (b != '1) o.result = na ? 64'd0 - ma % mb : ma % mb;
         end
         OP_AND: o.result = a & b;
         OP_OR:  o.result = a | b;
         OP_XOR: o.result = a ^ b;
         OP_NEG, OP_ABS: begin
            if (a == Int64Min) o.status = ST_OVERFLOW;
            else o.result = (r.action == OP_NEG) ? 64'd0 - a : ma;
         end
         OP_NOT:  o.result = ~a;
         OP_EVEN: o.truth = ~a[0];
         OP_ODD:  o.truth = a[0];
         OP_EQ:   o.truth = a == b;
         OP_GE:   o.truth = $signed(a) >= $signed(b);
         OP_GT:   o.truth = $signed(a) > $signed(b);
         default: ;
      endcase
      if (o.status != ST_OK) o.result = '0;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %h want %h (response %0d)", what, got, want,
               checked_count);
   endtask

   // response checker and receiver stall
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.result, 64'd0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.result !== want.result)
               report_mismatch("result", rsp_data.result, want.result);
            if (rsp_data.truth !== want.truth)
               report_mismatch("truth", 64'(rsp_data.truth), 64'(want.truth));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
         end
         checked_count++;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired");
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // hold valid across back-to-back requests; drop it only while idling
   task automatic send_request(logic [4:0] act, logic [63:0] a, logic [63:0] b);
      req_type r;
      r.action = act;
      r.operand_a = a;
      r.operand_b = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(alu_outcome(r));
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // biased operand: corners, small values, 32-bit values, or full random
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(7))
         0: return Int64Min;
         1: return Int64Max;
         2: return '1;
         3: return 64'($signed($urandom_range(20)) - 10);
         4: return 64'($signed($urandom()));
         default: return rand64();
      endcase
   endfunction

   task automatic test_corners();
      logic [63:0] vals[6];
      vals = '{Int64Min, Int64Max, '1, 64'd0, 64'd1, 64'd7};
      for (int op = OP_COPY; op <= OP_GT; op += 2)
         send_request(op[4:0], vals[op % 6], vals[(op + 1) % 6]);
      send_request(OP_DIV, Int64Min, '1);
      send_request(OP_DIV, 64'd12, 64'd0);
      send_request(OP_DIV, 64'd13, 64'd4);
      send_request(OP_DIV, -64'sd12, 64'd4);
      send_request(OP_REM, -64'sd13, 64'd4);
      send_request(OP_REM, Int64Min, '1);
      send_request(OP_MUL, Int64Min, 64'd1);
      send_request(OP_MUL, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
      send_request(OP_ADD, Int64Max, 64'd1);
      send_request(OP_SUB, Int64Min, 64'd1);
      send_request(OP_NEG, Int64Min, '0);
      send_request(OP_ABS, Int64Min, '0);
      send_request(OP_GE, Int64Min, Int64Max);
      send_request(5'd31, rand64(), rand64());
   endtask

   task automatic test_random(int count, int idle_pct, int stall);
      logic [4:0] act;
      logic [63:0] a, b;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         act = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 17))
                                         : 5'($urandom_range(16));
         a = pick_operand();
         b = pick_operand();
         // steer some divides toward exact quotients
         if (act == OP_DIV && $urandom_range(1) == 0) a = 64'($signed(b) * $urandom_range(99));
         send_request(act, a, b);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   initial begin
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_corners();
      test_random(250, 0, 0);
      test_random(150, 84, 0);
      test_random(150, 0, 84);
      test_random(250, 10, 10);
      drain();
      $display("sent %0d requests over all operations and corner operands,", sent_count);
      $display("checked %0d responses under four idling patterns", checked_count);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
